// ===== hw/rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants for the bounded identifier set.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    // Set capacity and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ID_W     = 32;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Request item
    typedef struct packed {
        logic [1:0]             req_type;
        logic signed [ID_W-1:0] object_id;
    } req_t;

    // Result item
    typedef struct packed {
        logic               found;
        logic               added;
        logic [COUNT_W-1:0] fill_count;
    } rsp_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_id_set_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_id_set_unit
// Fixed-capacity identifier set with duplicate check, scanned one entry
// per cycle.
// ----------------------------------------------------------------------------
// An insert or query walks the held identifiers, and a match ends the scan
// early; clear and unused codes skip the scan. A result that is still held
// when the next item finishes keeps that item waiting until m_ready takes
// the result. The scan is bounded by the single read port of the identifier
// store, which the sequencer walks one entry per cycle in insertion order.
// The block takes one item at a time; the result waits in an output
// register, and the next item is accepted while it is still held there.
`default_nettype none

module bounded_id_set_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bis_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bis_pkg::rsp_t      m_data
);

    bis_pkg::state_t state_reg, state_next;

    logic [bis_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [bis_pkg::COUNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic                        pend_reg, pend_next;
    logic                        hit_reg, hit_next;
    logic [1:0]                  kind_reg;
    logic [bis_pkg::ID_W-1:0]    id_reg;
    logic                        m_valid_reg, m_valid_next;
    bis_pkg::rsp_t               m_data_reg, m_data_next;

    logic                        accept;
    logic                        match;
    logic                        issue;
    logic                        out_free;
    logic                        do_add;
    logic                        wr_en;
    logic [bis_pkg::ID_W-1:0]    rd_data;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign match    = pend_reg && (rd_data == id_reg);
    assign hit_next = (state_reg == bis_pkg::ST_SCAN) ? (hit_reg || match) : hit_reg;

    // Issue a read while entries remain and no match is seen
    assign issue  = (state_reg == bis_pkg::ST_SCAN) && (scan_addr_reg < count_reg)
                    && !hit_next;
    assign do_add = (kind_reg == bis_pkg::REQ_INSERT) && !hit_reg
                    && (count_reg < bis_pkg::COUNT_W'(bis_pkg::CAPACITY));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bis_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type inside {bis_pkg::REQ_INSERT, bis_pkg::REQ_QUERY}) begin
                        state_next = bis_pkg::ST_SCAN;
                    end else begin
                        state_next = bis_pkg::ST_FINISH;
                    end
                end
            end
            bis_pkg::ST_SCAN: begin
                if (!issue) begin
                    state_next = bis_pkg::ST_FINISH;
                end
            end
            bis_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = bis_pkg::ST_IDLE;
                end
            end
            default: state_next = bis_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        case (state_reg)
            bis_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                scan_addr_next = '0;
            end
            bis_pkg::ST_SCAN: begin
                pend_next = issue;
                if (issue) begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            bis_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    case (kind_reg)
                        bis_pkg::REQ_INSERT: begin
                            wr_en = do_add;
                            if (do_add) begin
                                count_next = count_reg + 1'b1;
                            end
                            m_data_next.found = hit_reg;
                            m_data_next.added = do_add;
                        end
                        bis_pkg::REQ_QUERY: begin
                            m_data_next.found = hit_reg;
                            m_data_next.added = 1'b0;
                        end
                        bis_pkg::REQ_CLEAR: begin
                            count_next        = '0;
                            m_data_next.found = 1'b0;
                            m_data_next.added = 1'b0;
                        end
                        default: begin
                            m_data_next.found = 1'b0;
                            m_data_next.added = 1'b0;
                        end
                    endcase
                    m_data_next.fill_count = count_next;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bis_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
            hit_reg       <= accept ? 1'b0 : hit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            kind_reg <= s_data.req_type;
            id_reg   <= s_data.object_id;
        end
    end

    bis_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[bis_pkg::ADDR_W-1:0]),
        .wr_data (id_reg),
        .rd_en   (issue),
        .rd_addr (scan_addr_reg[bis_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bis_store.sv =====
// ----------------------------------------------------------------------------
// bis_store
// Identifier storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_store (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [bis_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [bis_pkg::ID_W-1:0]    wr_data,
    input  wire logic                        rd_en,
    input  wire logic [bis_pkg::ADDR_W-1:0]  rd_addr,
    output logic      [bis_pkg::ID_W-1:0]    rd_data
);

    logic [bis_pkg::ID_W-1:0] mem [bis_pkg::CAPACITY];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bis_checker.sv =====
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks for the bounded identifier set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire bis_pkg::req_t s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire bis_pkg::rsp_t m_data
);

    // Reset drops the result item
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // One item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted item");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.fill_count <= bis_pkg::COUNT_W'(bis_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    // A new entry was never held before
    a_added_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.added && m_data.found))
        else $error("identifier both found and added");

endmodule

bind bounded_id_set_unit bis_checker u_bis_checker (.*);

`default_nettype wire

// ===== tb/bounded_id_set_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_id_set_unit_tb
// Self-checking bench for the bounded identifier set. A directed table covers
// the extremes of the identifier, every request code and the duplicate, clear
// and unused-code cases. Randomized bursts then fill the set to capacity,
// probe it with held and fresh identifiers and mix in noise, under three
// backpressure profiles. Checks use the typed rows or an in-bench model.
// ----------------------------------------------------------------------------

module bounded_id_set_unit_tb;

    localparam int         CLK_PERIOD  = 20;
    localparam int         STALL_LIMIT = 4000;
    localparam int         TAIL_CYCLES = 80;
    localparam int         ITEMS_PER_PHASE = 130;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         DIR_ROWS    = 19;

    // One row of the directed table
    typedef struct packed {
        logic [1:0]                  kind;
        logic [bis_pkg::ID_W-1:0]    id;
        logic                        typed;
        logic                        found;
        logic                        added;
        logic [bis_pkg::COUNT_W-1:0] count;
    } stim_row_t;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    bis_pkg::req_t  s_data;
    logic           m_valid;
    logic           m_ready;
    bis_pkg::rsp_t  m_data;

    // Model of the set contents
    logic [bis_pkg::ID_W-1:0] set_ids [bis_pkg::CAPACITY];
    int                       set_size;

    bis_pkg::rsp_t expected_rsp_q [$];

    int errors;
    int n_sent;
    int n_checked;
    int n_stored;
    int n_full_reject;
    int n_hits;
    int src_idle_pct;
    int rcv_idle_pct;

    // Directed cases: typed expectations only where they are obvious
    stim_row_t dir_rows [DIR_ROWS] = '{
        {bis_pkg::REQ_QUERY,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_INSERT, 32'h8000_0000, 1'b1, 1'b0, 1'b1, 7'd1},
        {bis_pkg::REQ_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 7'd2},
        {bis_pkg::REQ_INSERT, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 7'd2},
        {bis_pkg::REQ_QUERY,  32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 7'd2},
        {bis_pkg::REQ_QUERY,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 7'd2},
        {bis_pkg::REQ_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 7'd3},
        {bis_pkg::REQ_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 7'd4},
        {bis_pkg::REQ_QUERY,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 7'd4},
        {REQ_UNUSED,          32'h8000_0000, 1'b1, 1'b0, 1'b0, 7'd4},
        {bis_pkg::REQ_CLEAR,  32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_QUERY,  32'h8000_0000, 1'b1, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 7'd1},
        {bis_pkg::REQ_INSERT, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_QUERY,  32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 7'd0},
        {REQ_UNUSED,          32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_CLEAR,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 7'd0},
        {bis_pkg::REQ_CLEAR,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 7'd0}
    };

    bounded_id_set_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Apply one request to the model and return the result it yields
    function automatic bis_pkg::rsp_t apply_request(bis_pkg::req_t r);
        bis_pkg::rsp_t rsp;
        logic hit;
        rsp = '0;
        hit = 1'b0;
        if (r.req_type == bis_pkg::REQ_INSERT || r.req_type == bis_pkg::REQ_QUERY) begin
            for (int i = 0; i < set_size; i++) begin
                if (set_ids[i] == r.object_id) hit = 1'b1;
            end
            if (hit) n_hits++;
        end
        if (r.req_type == bis_pkg::REQ_INSERT && !hit) begin
            if (set_size < bis_pkg::CAPACITY) begin
                set_ids[set_size] = r.object_id;
                set_size++;
                rsp.added = 1'b1;
                n_stored++;
            end else begin
                n_full_reject++;
            end
        end else if (r.req_type == bis_pkg::REQ_CLEAR) begin
            set_size = 0;
        end
        rsp.found      = hit;
        rsp.fill_count = set_size[bis_pkg::COUNT_W-1:0];
        return rsp;
    endfunction

    function automatic logic [bis_pkg::ID_W-1:0] fresh_id();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 32'h8000_0000;
        if (roll == 1) return 32'h7FFF_FFFF;
        if (roll == 2) return 32'hFFFF_FFFF;
        if (roll == 3) return 32'h0000_0000;
        return $urandom;
    endfunction

    // Half the time reuse a held identifier, when there is one
    function automatic logic [bis_pkg::ID_W-1:0] some_id();
        if (set_size > 0 && $urandom_range(0, 1) == 1)
            return set_ids[$urandom_range(0, set_size - 1)];
        return fresh_id();
    endfunction

    function automatic void compare_field(string name, logic [bis_pkg::COUNT_W-1:0] want_v,
                                          logic [bis_pkg::COUNT_W-1:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    // Present one item, hold it until accepted, then log its expected result
    task automatic send_req(input logic [1:0] kind, input logic [bis_pkg::ID_W-1:0] id,
                            input bit typed, input bis_pkg::rsp_t typed_rsp);
        bis_pkg::req_t r;
        bis_pkg::rsp_t want;
        r.req_type  = kind;
        r.object_id = id;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = apply_request(r);
        if (typed) want = typed_rsp;
        expected_rsp_q.push_back(want);
        n_sent++;
    endtask

    task automatic send_random(input logic [1:0] kind, input logic [bis_pkg::ID_W-1:0] id);
        send_req(kind, id, 1'b0, '0);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Clear, fill to capacity, then hit the full set with new and held ids
    task automatic run_fill_sequence();
        int roll;
        send_random(bis_pkg::REQ_CLEAR, $urandom);
        while (set_size < bis_pkg::CAPACITY) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                send_random(bis_pkg::REQ_INSERT, fresh_id());
            else if (roll < 85)
                send_random(bis_pkg::REQ_INSERT, some_id());
            else
                send_random(bis_pkg::REQ_QUERY, some_id());
        end
        repeat (3) send_random(bis_pkg::REQ_INSERT, fresh_id());
        send_random(bis_pkg::REQ_INSERT, set_ids[$urandom_range(0, bis_pkg::CAPACITY - 1)]);
        send_random(bis_pkg::REQ_QUERY, set_ids[bis_pkg::CAPACITY - 1]);
        send_random(bis_pkg::REQ_QUERY, fresh_id());
    endtask

    // Mostly well-formed traffic with a share of noise
    task automatic run_mixed_burst(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_random(bis_pkg::REQ_INSERT, some_id());
            else if (roll < 82)
                send_random(bis_pkg::REQ_QUERY, some_id());
            else if (roll < 87)
                send_random(bis_pkg::REQ_CLEAR, $urandom);
            else if (roll < 92)
                send_random(REQ_UNUSED, some_id());
            else
                send_random(2'($urandom_range(0, 3)), $urandom);
        end
    endtask

    // Receiver backpressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Check each result against the oldest expectation
    always @(posedge aclk) begin : check_results
        bis_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0b/%0b/%0d",
                         $time, m_data.found, m_data.added, m_data.fill_count);
            end else begin
                want = expected_rsp_q.pop_front();
                compare_field("found", bis_pkg::COUNT_W'(want.found),
                              bis_pkg::COUNT_W'(m_data.found));
                compare_field("added", bis_pkg::COUNT_W'(want.added),
                              bis_pkg::COUNT_W'(m_data.added));
                compare_field("fill_count", want.fill_count, m_data.fill_count);
                n_checked++;
            end
        end
    end

    // End the run when no item moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        stim_row_t     row;
        bis_pkg::rsp_t typed_rsp;
        errors        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_stored      = 0;
        n_full_reject = 0;
        n_hits        = 0;
        set_size      = 0;
        src_idle_pct  = 31;
        rcv_idle_pct  = 56;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;

        // Hold reset, then release
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row                  = dir_rows[i];
            typed_rsp.found      = row.found;
            typed_rsp.added      = row.added;
            typed_rsp.fill_count = row.count;
            send_req(row.kind, row.id, row.typed, typed_rsp);
        end
        wait_drained();

        // Randomized phases under three backpressure profiles
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 56 : 0;
            rcv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 31 : 0;
            run_fill_sequence();
            while (n_sent < DIR_ROWS + (ph + 1) * ITEMS_PER_PHASE)
                run_mixed_burst($urandom_range(8, 20));
            wait_drained();
        end

        // Let any stray result show up
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d requests through three backpressure profiles, %0d results checked.",
                 n_sent, n_checked);
        $display("Inserts stored %0d, rejected on a full set %0d, membership hits %0d.",
                 n_stored, n_full_reject, n_hits);
        if (errors == 0 && expected_rsp_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results missing", errors, expected_rsp_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
